// ===== rtl/nns_pkg.sv =====
// Shared constants and types for the nearest node search unit.
`timescale 1ns / 1ps

package nns_pkg;

   localparam int MAX_NODES     = 256;
   localparam int COORD_BITS    = 20;
   localparam int GID_BITS      = 16;
   localparam int DIST_BITS     = 44;
   localparam int OUT_IDX_BITS  = 8;
   localparam int OP_BITS       = 3;

   localparam int IDX_BITS      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_BITS      = $clog2(MAX_NODES + 1);
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * DIFF_BITS;
   localparam int SUM_BITS      = SQ_BITS + 2;
   localparam int CMP_BITS      = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

   localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(64'd40960000000);
   localparam logic signed [GID_BITS-1:0] NO_GID = -16'sd1;

   localparam logic [OP_BITS-1:0] OP_CLEAR          = 3'd0;
   localparam logic [OP_BITS-1:0] OP_APPEND         = 3'd1;
   localparam logic [OP_BITS-1:0] OP_NEAREST_ANY    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_NEAREST_GLOBAL = 3'd3;
   localparam logic [OP_BITS-1:0] OP_FIND_ID        = 3'd4;

   typedef struct packed {
      logic accept;
      logic issue;
      logic finish;
   } nns_cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_last;
      logic pipe_busy;
   } nns_status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic signed [GID_BITS-1:0]   gid;
   } nns_entry_type;

endpackage

// ===== rtl/nns_controller.sv =====
// Sequencer for one operation: accept, table scan, pipeline drain, result load.
`timescale 1ns / 1ps

module nns_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  nns_pkg::nns_status_type status,
   output nns_pkg::nns_cmd_type   cmd
);
   import nns_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } nns_state_type;

   nns_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.start_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // load the result only once the output slot is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/nns_datapath.sv =====
// Node table, distance pipeline, running minimum and result registers.
`timescale 1ns / 1ps

module nns_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [nns_pkg::OP_BITS-1:0]          req_operation,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_z,
   input  logic signed [nns_pkg::GID_BITS-1:0]   req_global_id,
   input  logic                                 csr_write_enable,
   input  logic [nns_pkg::DIST_BITS-1:0]        csr_write_data,
   input  nns_pkg::nns_cmd_type                 cmd,
   output nns_pkg::nns_status_type              status,
   output logic                                 rsp_found,
   output logic [nns_pkg::OUT_IDX_BITS-1:0]     rsp_match_index,
   output logic [nns_pkg::DIST_BITS-1:0]        rsp_best_distance_sq,
   output logic                                 rsp_table_full
);
   import nns_pkg::*;

   nns_entry_type node_mem [MAX_NODES];

   logic [DIST_BITS-1:0]         max_dist_ff;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         table_is_full;
   logic                         mem_we;
   nns_entry_type                wr_entry;

   logic [OP_BITS-1:0]           q_op_ff;
   logic signed [COORD_BITS-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic signed [GID_BITS-1:0]   q_gid_ff;
   logic                         full_ff;

   logic [IDX_BITS-1:0]          scan_idx_ff;

   // stage 1: registered table read
   logic                         v1_ff;
   logic [IDX_BITS-1:0]          idx1_ff;
   nns_entry_type                rd_ff;
   // stage 2: absolute differences
   logic                         v2_ff;
   logic [IDX_BITS-1:0]          idx2_ff;
   logic [DIFF_BITS-1:0]         ax2_ff, ay2_ff, az2_ff;
   logic                         hit2_ff, skip2_ff;
   // stage 3: squares
   logic                         v3_ff;
   logic [IDX_BITS-1:0]          idx3_ff;
   logic [SQ_BITS-1:0]           sx3_ff, sy3_ff, sz3_ff;
   logic                         hit3_ff, skip3_ff;
   // stage 4: sum of squares
   logic                         v4_ff;
   logic [IDX_BITS-1:0]          idx4_ff;
   logic [SUM_BITS-1:0]          sum4_ff;
   logic                         hit4_ff, skip4_ff;

   logic [DIST_BITS-1:0]         best_ff;
   logic                         found_ff;
   logic [IDX_BITS-1:0]          idx_ff;

   logic signed [DIFF_BITS-1:0]  dx, dy, dz;
   logic [DIFF_BITS-1:0]         ax, ay, az;
   logic                         is_nearest;
   logic                         closer;
   logic [IDX_BITS+OUT_IDX_BITS-1:0] idx_wide;

   // ---------------------------------------------------------------- table
   assign table_is_full = (count_ff == CNT_BITS'(MAX_NODES));
   assign mem_we = cmd.accept && (req_operation == OP_APPEND) && !table_is_full;
   assign wr_entry = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, gid: req_global_id};

   always_comb begin
      count_in = count_ff;
      if (cmd.accept) begin
         if (req_operation == OP_CLEAR) begin
            count_in = '0;
         end else if (mem_we) begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[count_ff[IDX_BITS-1:0]] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ff <= node_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         max_dist_ff <= DIST_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_write_enable) begin
            max_dist_ff <= csr_write_data;
         end
      end
   end

   // ---------------------------------------------------------------- status
   assign status.start_scan =
      (req_operation inside {OP_NEAREST_ANY, OP_NEAREST_GLOBAL, OP_FIND_ID}) &&
      (count_ff != '0);

   assign status.scan_last = (CNT_BITS'(scan_idx_ff) == (count_ff - CNT_BITS'(1)));
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   // ---------------------------------------------------------------- query
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_op_ff  <= req_operation;
         q_x_ff   <= req_pos_x;
         q_y_ff   <= req_pos_y;
         q_z_ff   <= req_pos_z;
         q_gid_ff <= req_global_id;
         full_ff  <= (req_operation == OP_APPEND) && table_is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         scan_idx_ff <= '0;
      end else if (cmd.issue) begin
         scan_idx_ff <= scan_idx_ff + IDX_BITS'(1);
      end
   end

   // ---------------------------------------------------------------- pipeline
   always_comb begin
      dx = DIFF_BITS'(q_x_ff) - DIFF_BITS'(rd_ff.x);
      dy = DIFF_BITS'(q_y_ff) - DIFF_BITS'(rd_ff.y);
      dz = DIFF_BITS'(q_z_ff) - DIFF_BITS'(rd_ff.z);
      ax = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
      ay = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
      az = dz[DIFF_BITS-1] ? DIFF_BITS'(-dz) : DIFF_BITS'(dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= scan_idx_ff;

      idx2_ff  <= idx1_ff;
      ax2_ff   <= ax;
      ay2_ff   <= ay;
      az2_ff   <= az;
      hit2_ff  <= (rd_ff.gid == q_gid_ff);
      skip2_ff <= (q_op_ff == OP_NEAREST_GLOBAL) && (rd_ff.gid == NO_GID);

      idx3_ff  <= idx2_ff;
      sx3_ff   <= SQ_BITS'(ax2_ff) * SQ_BITS'(ax2_ff);
      sy3_ff   <= SQ_BITS'(ay2_ff) * SQ_BITS'(ay2_ff);
      sz3_ff   <= SQ_BITS'(az2_ff) * SQ_BITS'(az2_ff);
      hit3_ff  <= hit2_ff;
      skip3_ff <= skip2_ff;

      idx4_ff  <= idx3_ff;
      sum4_ff  <= SUM_BITS'(sx3_ff) + SUM_BITS'(sy3_ff) + SUM_BITS'(sz3_ff);
      hit4_ff  <= hit3_ff;
      skip4_ff <= skip3_ff;
   end

   // ---------------------------------------------------------------- running best
   assign is_nearest = (q_op_ff == OP_NEAREST_ANY) || (q_op_ff == OP_NEAREST_GLOBAL);
   assign closer     = (CMP_BITS'(sum4_ff) < CMP_BITS'(best_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         best_ff  <= max_dist_ff;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (v4_ff) begin
         case (q_op_ff)
            OP_NEAREST_ANY, OP_NEAREST_GLOBAL: begin
               if (!skip4_ff && closer) begin
                  best_ff  <= DIST_BITS'(sum4_ff);
                  found_ff <= 1'b1;
                  idx_ff   <= idx4_ff;
               end
            end
            OP_FIND_ID: begin
               // keep the first matching id
               if (hit4_ff && !found_ff) begin
                  found_ff <= 1'b1;
                  idx_ff   <= idx4_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- result
   assign idx_wide = {OUT_IDX_BITS'(0), idx_ff};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found            <= found_ff;
         rsp_match_index      <= idx_wide[OUT_IDX_BITS-1:0];
         rsp_best_distance_sq <= (found_ff && is_nearest) ? best_ff : '0;
         rsp_table_full       <= full_ff;
      end
   end

endmodule

// ===== rtl/nearest_node_search_unit.sv =====
// Top level of the nearest node search unit: controller plus datapath.
`timescale 1ns / 1ps

// A table of up to MAX_NODES 3D nodes (Q16.4 coordinates, 16-bit global id)
// with one result per request. Clear, append and unknown operations skip
// the table scan and go straight to the result load. A nearest or find-id
// query reads the table through one memory read port, one node per cycle,
// then drains a four-stage distance pipeline; on an empty table it skips
// the scan too. The node memory needs no clearing pass after reset. A new
// request is taken once the previous result has been loaded into the output
// register, even while that result is still stalled. Write max_distance_sq
// only while no request is in progress.
module nearest_node_search_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nns_pkg::OP_BITS-1:0]          req_operation,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [nns_pkg::COORD_BITS-1:0] req_pos_z,
   input  logic signed [nns_pkg::GID_BITS-1:0]   req_global_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [nns_pkg::OUT_IDX_BITS-1:0]     rsp_match_index,
   output logic [nns_pkg::DIST_BITS-1:0]        rsp_best_distance_sq,
   output logic                                 rsp_table_full,
   input  logic                                 csr_write_enable,
   input  logic [nns_pkg::DIST_BITS-1:0]        csr_write_data
);
   import nns_pkg::*;

   nns_cmd_type    cmd;
   nns_status_type status;

   nns_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nns_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_operation        (req_operation),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .req_global_id        (req_global_id),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_found            (rsp_found),
      .rsp_match_index      (rsp_match_index),
      .rsp_best_distance_sq (rsp_best_distance_sq),
      .rsp_table_full       (rsp_table_full)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the nearest node search unit.
`timescale 1ns / 1ps

module tb;
   import nns_pkg::*;

   localparam int ITEM_TARGET     = 1850;
   localparam int PHASE_COUNT     = 6;
   localparam int RANDOM_PHASE    = 3;
   localparam int REPORT_LIMIT    = 10;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PRESSURE_AFTER  = 300;
   localparam int PRESSURE_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 300;

   localparam logic [OP_BITS-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_BITS-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SPARE_HI  = 3'd7;

   localparam logic signed [COORD_BITS-1:0] COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_ZERO   = '0;
   localparam logic signed [GID_BITS-1:0]   GID_TOP      = {1'b0, {(GID_BITS-1){1'b1}}};
   localparam logic [DIST_BITS-1:0]         CEILING_TOP  = '1;

   typedef struct packed {
      logic [OP_BITS-1:0]           op;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic signed [GID_BITS-1:0]   gid;
   } search_request_t;

   typedef struct packed {
      logic                    found;
      logic [OUT_IDX_BITS-1:0] index;
      logic [DIST_BITS-1:0]    dist_sq;
      logic                    full;
   } search_outcome_t;

   typedef struct packed {
      search_request_t req;
      logic            typed;
      search_outcome_t want;
   } probe_row_t;

   localparam search_outcome_t NO_MATCH = '0;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [OP_BITS-1:0]            req_operation;
   logic signed [COORD_BITS-1:0]  req_pos_x;
   logic signed [COORD_BITS-1:0]  req_pos_y;
   logic signed [COORD_BITS-1:0]  req_pos_z;
   logic signed [GID_BITS-1:0]    req_global_id;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_found;
   logic [OUT_IDX_BITS-1:0]       rsp_match_index;
   logic [DIST_BITS-1:0]          rsp_best_distance_sq;
   logic                          rsp_table_full;
   logic                          csr_write_enable;
   logic [DIST_BITS-1:0]          csr_write_data;

   nearest_node_search_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .req_global_id        (req_global_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_match_index      (rsp_match_index),
      .rsp_best_distance_sq (rsp_best_distance_sq),
      .rsp_table_full       (rsp_table_full),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the node table and the distance ceiling
   nns_entry_type        node_copy [MAX_NODES];
   int                   node_total;
   logic [DIST_BITS-1:0] distance_ceiling;

   search_outcome_t pending_outcomes [$];

   bit  calm;
   bit  pressure_done;
   int  fault_count;
   int  outcomes_seen;
   int  found_total;
   int  refused_total;
   int  stim_items;
   int  ceiling_writes;
   int  quiet_cycles;
   int  op_tally [8];

   logic [DIST_BITS-1:0] ceiling_plan [PHASE_COUNT] =
      '{CEILING_TOP, '0, 44'd256, '0, DIST_RESET, 44'd1000000};

   // directed probes: empty table, unused codes, extremes, ties, id lookups
   probe_row_t probe_table [25] = '{
      '{'{OP_NEAREST_ANY, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd0}, 1'b1, NO_MATCH},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, NO_GID}, 1'b1, NO_MATCH},
      '{'{OP_SPARE_LO, COORD_TOP, COORD_TOP, COORD_TOP, GID_TOP}, 1'b1, NO_MATCH},
      '{'{OP_SPARE_MID, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, NO_GID}, 1'b1, NO_MATCH},
      '{'{OP_SPARE_HI, COORD_TOP, COORD_BOTTOM, COORD_TOP, 16'sd0}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, COORD_TOP, COORD_BOTTOM, COORD_TOP, GID_TOP}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, NO_GID}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd0}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd7}, 1'b1, NO_MATCH},
      '{'{OP_NEAREST_ANY, COORD_TOP, COORD_BOTTOM, COORD_TOP, 16'sd0}, 1'b1,
        '{1'b1, 8'd0, 44'd0, 1'b0}},
      '{'{OP_NEAREST_ANY, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, 16'sd0}, 1'b1,
        '{1'b1, 8'd1, 44'd0, 1'b0}},
      '{'{OP_NEAREST_ANY, 20'sd16, COORD_ZERO, COORD_ZERO, 16'sd0}, 1'b1,
        '{1'b1, 8'd2, 44'd256, 1'b0}},
      '{'{OP_NEAREST_GLOBAL, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, 16'sd0}, 1'b0, NO_MATCH},
      '{'{OP_NEAREST_GLOBAL, COORD_ZERO, COORD_ZERO, 20'sd16, NO_GID}, 1'b0, NO_MATCH},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, NO_GID}, 1'b1,
        '{1'b1, 8'd1, 44'd0, 1'b0}},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, GID_TOP}, 1'b1,
        '{1'b1, 8'd0, 44'd0, 1'b0}},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd7}, 1'b1,
        '{1'b1, 8'd3, 44'd0, 1'b0}},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd100}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, -20'sd16, -20'sd16, -20'sd16, 16'sd100}, 1'b1, NO_MATCH},
      '{'{OP_NEAREST_ANY, -20'sd8, -20'sd8, -20'sd8, 16'sd0}, 1'b0, NO_MATCH},
      '{'{OP_CLEAR, COORD_TOP, COORD_TOP, COORD_TOP, GID_TOP}, 1'b1, NO_MATCH},
      '{'{OP_NEAREST_ANY, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd0}, 1'b1, NO_MATCH},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd0}, 1'b1, NO_MATCH},
      '{'{OP_APPEND, 20'sd5, 20'sd5, 20'sd5, 16'sd3}, 1'b1, NO_MATCH},
      '{'{OP_FIND_ID, COORD_ZERO, COORD_ZERO, COORD_ZERO, 16'sd3}, 1'b1,
        '{1'b1, 8'd0, 44'd0, 1'b0}}
   };

   // apply one request to the shadow table and return the result it should give
   function automatic search_outcome_t predict_search(input search_request_t r);
      search_outcome_t   o;
      longint            dx, dy, dz;
      longint unsigned   d, best;
      o = '0;
      best = distance_ceiling;
      case (r.op)
         OP_CLEAR: node_total = 0;
         OP_APPEND: begin
            if (node_total >= MAX_NODES) begin
               o.full = 1'b1;
            end else begin
               node_copy[node_total] = '{r.x, r.y, r.z, r.gid};
               node_total++;
            end
         end
         OP_NEAREST_ANY, OP_NEAREST_GLOBAL: begin
            for (int i = 0; i < node_total; i++) begin
               if (r.op == OP_NEAREST_GLOBAL && node_copy[i].gid == NO_GID) continue;
               dx = longint'($signed(r.x)) - longint'($signed(node_copy[i].x));
               dy = longint'($signed(r.y)) - longint'($signed(node_copy[i].y));
               dz = longint'($signed(r.z)) - longint'($signed(node_copy[i].z));
               d = dx * dx + dy * dy + dz * dz;
               // strictly smaller only: ties keep the earlier node
               if (d < best) begin
                  best = d;
                  o.found = 1'b1;
                  o.index = OUT_IDX_BITS'(i);
               end
            end
            if (o.found) o.dist_sq = best[DIST_BITS-1:0];
         end
         OP_FIND_ID: begin
            for (int i = 0; i < node_total; i++) begin
               if (node_copy[i].gid == r.gid) begin
                  o.found = 1'b1;
                  o.index = OUT_IDX_BITS'(i);
                  break;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return COORD_TOP;
      if (pick == 1) return COORD_BOTTOM;
      if (pick < 9) return COORD_BITS'(int'($urandom_range(0, 4000)) - 2000);
      return COORD_BITS'($urandom);
   endfunction

   function automatic logic signed [GID_BITS-1:0] rand_gid();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 5) return NO_GID;
      if (pick < 17) return GID_BITS'($urandom_range(0, 40));
      if (pick < 19) return GID_TOP;
      return GID_BITS'($urandom_range(0, 32767));
   endfunction

   function automatic logic [OP_BITS-1:0] spare_op();
      case ($urandom_range(0, 2))
         0: return OP_SPARE_LO;
         1: return OP_SPARE_MID;
         default: return OP_SPARE_HI;
      endcase
   endfunction

   function automatic search_request_t random_fields(input logic [OP_BITS-1:0] op);
      search_request_t r;
      r.op = op;
      r.x = rand_coord();
      r.y = rand_coord();
      r.z = rand_coord();
      r.gid = rand_gid();
      return r;
   endfunction

   // queries mostly aim near a stored node so that small ceilings still match
   function automatic search_request_t random_query();
      search_request_t r;
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r = random_fields(OP_NEAREST_ANY);
         4, 5, 6:    r = random_fields(OP_NEAREST_GLOBAL);
         default:    r = random_fields(OP_FIND_ID);
      endcase
      if (node_total > 0 && $urandom_range(0, 9) < 6) begin
         k = $urandom_range(0, node_total - 1);
         r.gid = node_copy[k].gid;
         if ($urandom_range(0, 5) == 0) begin
            r.x = node_copy[k].x + COORD_BITS'(16);
            r.y = node_copy[k].y;
            r.z = node_copy[k].z;
         end else begin
            r.x = node_copy[k].x + COORD_BITS'(int'($urandom_range(0, 40)) - 20);
            r.y = node_copy[k].y + COORD_BITS'(int'($urandom_range(0, 40)) - 20);
            r.z = node_copy[k].z + COORD_BITS'(int'($urandom_range(0, 40)) - 20);
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic issue_request(input search_request_t r, input logic typed,
                                input search_outcome_t want);
      int gap;
      search_outcome_t predicted;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= r.op;
      req_pos_x     <= r.x;
      req_pos_y     <= r.y;
      req_pos_z     <= r.z;
      req_global_id <= r.gid;
      do @(posedge clock); while (req_stall);
      predicted = predict_search(r);
      pending_outcomes.push_back(typed ? want : predicted);
      op_tally[r.op]++;
      if (r.op <= OP_FIND_ID) stim_items++;
   endtask

   task automatic load_ceiling(input logic [DIST_BITS-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      distance_ceiling = value;
      ceiling_writes++;
   endtask

   // clear, fill with nodes, then query; a little noise and a few broken sets
   task automatic run_search_set(input bit fill_table);
      int node_goal, query_goal, pick;
      pick = $urandom_range(0, 99);
      calm = ($urandom_range(0, 7) == 0);
      if (fill_table) node_goal = MAX_NODES + $urandom_range(1, 4);
      else if (pick < 70) node_goal = $urandom_range(1, 12);
      else if (pick < 93) node_goal = $urandom_range(13, 64);
      else node_goal = 0;
      if (fill_table || $urandom_range(0, 9) != 0)
         issue_request(random_fields(OP_CLEAR), 1'b0, NO_MATCH);
      repeat (node_goal) begin
         pick = $urandom_range(0, 59);
         if (pick == 0) issue_request(random_fields(spare_op()), 1'b0, NO_MATCH);
         else if (pick == 1) issue_request(random_query(), 1'b0, NO_MATCH);
         else if (pick == 2) issue_request(random_fields(OP_CLEAR), 1'b0, NO_MATCH);
         issue_request(random_fields(OP_APPEND), 1'b0, NO_MATCH);
      end
      query_goal = $urandom_range(3, 14);
      repeat (query_goal) begin
         if ($urandom_range(0, 19) == 0)
            issue_request(random_fields(spare_op()), 1'b0, NO_MATCH);
         issue_request(random_query(), 1'b0, NO_MATCH);
      end
   endtask

   initial begin : stimulus
      logic [63:0] wide;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_CLEAR;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      req_global_id    = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      node_total       = 0;
      distance_ceiling = DIST_RESET;
      calm             = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (probe_table[i])
         issue_request(probe_table[i].req, probe_table[i].typed, probe_table[i].want);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == RANDOM_PHASE) begin
            wide = {$urandom, $urandom};
            ceiling_plan[phase] = wide[DIST_BITS-1:0] >> $urandom_range(0, 16);
         end
         load_ceiling(ceiling_plan[phase]);
         run_search_set(phase == 0 || phase == PHASE_COUNT - 2);
         while (stim_items < ((phase + 1) * ITEM_TARGET) / PHASE_COUNT)
            run_search_set(1'b0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d requests (clear %0d, append %0d, nearest %0d,",
               stim_items, op_tally[OP_CLEAR], op_tally[OP_APPEND],
               op_tally[OP_NEAREST_ANY]);
      $display("  nearest-global %0d, find-id %0d, unused codes %0d);",
               op_tally[OP_NEAREST_GLOBAL], op_tally[OP_FIND_ID],
               op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_MID] + op_tally[OP_SPARE_HI]);
      $display("  %0d matches, %0d refused appends, %0d ceilings",
               found_total, refused_total, ceiling_writes);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : result_backpressure
      int run_left;
      int pick;
      run_left = 0;
      pressure_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && outcomes_seen >= PRESSURE_AFTER) begin
            // hold results long enough for the unit to back up into req_stall
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            pressure_done = 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(0, 11);
            end else if (pick < 92) begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(9, 49);
            end
         end
      end
   end

   always @(posedge clock) begin
      search_outcome_t got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_found, rsp_match_index, rsp_best_distance_sq, rsp_table_full};
         outcomes_seen++;
         if (got.found === 1'b1) found_total++;
         if (got.full === 1'b1) refused_total++;
         if (pending_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("%0t: transfer with nothing outstanding:", $time,
                        " found=%0d index=%0d dist=%0d full=%0d",
                        got.found, got.index, got.dist_sq, got.full);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.found !== want.found || got.index !== want.index ||
                got.dist_sq !== want.dist_sq || got.full !== want.full) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch expected found=%0d index=%0d dist=%0d full=%0d,",
                           $time, want.found, want.index, want.dist_sq, want.full);
                  $display("   got found=%0d index=%0d dist=%0d full=%0d",
                           got.found, got.index, got.dist_sq, got.full);
               end
            end
         end
      end
   end

   // end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_outcomes.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule

// ===== nearest_node_search_unit.f =====
rtl/nns_pkg.sv
rtl/nns_controller.sv
rtl/nns_datapath.sv
rtl/nearest_node_search_unit.sv
tb/sv/tb.sv
